// ===== src/bpi_pkg.sv =====
// Shared types and constants for the bicubic patch interpolator.
// No dependencies; imported by bpi_cubic, bpi_merge and the top level.
package bpi_pkg;

  typedef enum logic [1:0] {
    CUB_IDLE,
    CUB_H1,
    CUB_H2,
    CUB_WOUT
  } cub_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cub_stat_t;

  localparam logic [1:0] LAST_ROW = 2'd3;

endpackage

// ===== src/bpi_cubic.sv =====
// One Catmull-Rom cubic lane: coefficient setup plus a three-step Horner
// loop on a single shared multiplier. Depends on bpi_pkg.
module bpi_cubic import bpi_pkg::*; #(
  parameter int VW = 32,
  parameter int FW = 16,
  localparam int WW = VW + FW + 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [VW-1:0] v0,
  input  logic signed [VW-1:0] v1,
  input  logic signed [VW-1:0] v2,
  input  logic signed [VW-1:0] v3,
  input  logic        [FW:0]   t,
  output cub_stat_t            stat,
  output logic signed [WW-1:0] w
);

  localparam int CW = VW + 4;
  localparam int HW = VW + 5;
  localparam int PW = HW + FW + 2;

  cub_state_t state, state_next;
  logic done;

  logic signed [CW-1:0] e0, e1, e2, e3, d12;
  logic signed [CW-1:0] c1w, c2w, c3w;
  logic signed [CW-1:0] c1, c2, coef_sel;
  logic signed [VW-1:0] v1r;
  logic        [FW:0]   tr;
  logic signed [HW-1:0] h, step_sum;
  logic signed [PW-1:0] prod;
  logic signed [PW-FW-1:0] prod_sh;
  logic signed [WW-1:0] w_next;

  always_comb begin
    e0  = CW'(v0);
    e1  = CW'(v1);
    e2  = CW'(v2);
    e3  = CW'(v3);
    d12 = e1 - e2;
    c1w = e2 - e0;
    c2w = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    c3w = (d12 <<< 1) + d12 + e3 - e0;
  end

  // shared multiplier, floor shift, accumulate
  always_comb begin
    prod     = h * $signed({1'b0, tr});
    prod_sh  = prod[PW-1:FW];
    coef_sel = (state == CUB_H1) ? c2 : c1;
    step_sum = HW'(coef_sel) + HW'(prod_sh);
    w_next   = (WW'(v1r) <<< (FW + 1)) + WW'(prod);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CUB_IDLE: if (start) state_next = CUB_H1;
      CUB_H1:   state_next = CUB_H2;
      CUB_H2:   state_next = CUB_WOUT;
      CUB_WOUT: state_next = CUB_IDLE;
    endcase
    stat.busy = (state != CUB_IDLE);
    stat.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CUB_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == CUB_WOUT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      CUB_IDLE: begin
        if (start) begin
          c1  <= c1w;
          c2  <= c2w;
          h   <= HW'(c3w);
          v1r <= v1;
          tr  <= t;
        end
      end
      CUB_H1, CUB_H2: h <= step_sum;
      CUB_WOUT: w <= w_next;
    endcase
  end

endmodule

// ===== src/bpi_merge.sv =====
// Merge stage: rounds the patch cubic to an integer, saturates it and holds
// it in the response register until taken. Depends on bpi_pkg.
module bpi_merge import bpi_pkg::*; #(
  parameter int SW = 16,
  parameter int FW = 16,
  parameter int WW = 59
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cub_stat_t            pstat,
  input  logic signed [WW-1:0] w,
  output logic                 busy,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic signed [SW:0]   interp_value
);

  localparam int RW = WW - 2 * FW - 1;
  localparam logic signed [WW-1:0] RND   = WW'(1) << (2 * FW);
  localparam logic signed [RW-1:0] O_MAX = RW'((2 ** SW) - 1);
  localparam logic signed [RW-1:0] O_MIN = RW'(-(2 ** SW));

  logic signed [WW-1:0] sum;
  logic signed [RW-1:0] r, r_sat;
  logic pend, have, move;

  always_comb begin
    sum = w + RND;
    r   = sum[WW-1:2*FW+1];
    if (r > O_MAX) begin
      r_sat = O_MAX;
    end else if (r < O_MIN) begin
      r_sat = O_MIN;
    end else begin
      r_sat = r;
    end
    have = pstat.done | pend;
    move = have & (~rsp_valid | ~rsp_stall);
    busy = pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      pend      <= have & ~move;
      rsp_valid <= move | (rsp_valid & rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (move) interp_value <= r_sat[SW:0];
  end

endmodule

// ===== src/bicubic_patch_interpolator.sv =====
// Catmull-Rom bicubic interpolator over a 4x4 patch delivered row by row.
// Depends on bpi_pkg, bpi_cubic (row and patch lanes) and bpi_merge.
//
// Usage:
//   Request channel (req_valid/req_stall): one patch row per request, four
//   signed samples plus inner and outer fractions (Q1.FRAC_WIDTH, clamped
//   to 1.0). frac_outer is only used on the fourth row of a patch.
//   Response channel (rsp_valid/rsp_stall): one rounded, saturated value
//   per patch, issued after the fourth row.
//   Rows: the row lane takes no new row until it has finished the last one
//   (a setup step plus three Horner steps on its single multiplier).
//   Order: the fourth row passes through the row lane, then the patch lane,
//   then the response register; the patch lane runs in parallel with the
//   row lane, so the next patch's rows are taken while it finishes.
//   Reset: the row counter returns to the first row; nothing is pending.
//   A stalled response holds its value. The fourth row of the next patch
//   is held off while the patch lane is busy or the previous result still waits.
module bicubic_patch_interpolator import bpi_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_a,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_b,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_c,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_d,
  input  logic        [FRAC_WIDTH:0]    frac_inner,
  input  logic        [FRAC_WIDTH:0]    frac_outer,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic signed [SAMPLE_WIDTH:0]  interp_value
);

  localparam int RVW = SAMPLE_WIDTH + FRAC_WIDTH;
  localparam int RWW = RVW + FRAC_WIDTH + 8;
  localparam int PTW = SAMPLE_WIDTH + FRAC_WIDTH + 3;
  localparam int PWW = PTW + FRAC_WIDTH + 8;
  localparam logic [FRAC_WIDTH:0] ONE = {1'b1, {FRAC_WIDTH{1'b0}}};
  localparam logic signed [RWW-1:0] ROW_RND = RWW'(ONE);

  logic signed [RVW-1:0] sa, sb, sc, sd;
  logic        [FRAC_WIDTH:0] ti, to;
  logic        [FRAC_WIDTH:0] outer_t;
  logic [1:0] row_index, row_sel;
  logic accept, patch_start, patch_free, merge_busy;

  cub_stat_t row_stat, patch_stat;
  logic signed [RWW-1:0] row_w, row_sum;
  logic signed [PWW-1:0] patch_w;
  logic signed [PTW-1:0] part_new;
  logic signed [PTW-1:0] row_partials [3];

  always_comb begin
    sa = {sample_a, {FRAC_WIDTH{1'b0}}};
    sb = {sample_b, {FRAC_WIDTH{1'b0}}};
    sc = {sample_c, {FRAC_WIDTH{1'b0}}};
    sd = {sample_d, {FRAC_WIDTH{1'b0}}};
    ti = (frac_inner > ONE) ? ONE : frac_inner;
    to = (frac_outer > ONE) ? ONE : frac_outer;
    row_sum  = row_w + ROW_RND;
    part_new = row_sum[FRAC_WIDTH+PTW:FRAC_WIDTH+1];
    patch_free  = ~patch_stat.busy & ~patch_stat.done & ~merge_busy;
    req_stall   = row_stat.busy | ((row_index == LAST_ROW) & ~patch_free);
    accept      = req_valid & ~req_stall;
    patch_start = row_stat.done & (row_sel == LAST_ROW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= '0;
      row_sel   <= '0;
    end else if (accept) begin
      row_index <= row_index + 2'd1;
      row_sel   <= row_index;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && row_index == LAST_ROW) outer_t <= to;
    if (row_stat.done && row_sel != LAST_ROW) row_partials[row_sel] <= part_new;
  end

  bpi_cubic #(.VW(RVW), .FW(FRAC_WIDTH)) u_row_lane (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .v0    (sa),
    .v1    (sb),
    .v2    (sc),
    .v3    (sd),
    .t     (ti),
    .stat  (row_stat),
    .w     (row_w)
  );

  bpi_cubic #(.VW(PTW), .FW(FRAC_WIDTH)) u_patch_lane (
    .clk   (clk),
    .rst   (rst),
    .start (patch_start),
    .v0    (row_partials[0]),
    .v1    (row_partials[1]),
    .v2    (row_partials[2]),
    .v3    (part_new),
    .t     (outer_t),
    .stat  (patch_stat),
    .w     (patch_w)
  );

  bpi_merge #(.SW(SAMPLE_WIDTH), .FW(FRAC_WIDTH), .WW(PWW)) u_merge (
    .clk          (clk),
    .rst          (rst),
    .pstat        (patch_stat),
    .w            (patch_w),
    .busy         (merge_busy),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .interp_value (interp_value)
  );

  // the last row of a patch must find the patch lane free
  a_patch_free: assert property (@(posedge clk) disable iff (rst)
    patch_start |-> patch_free)
    else $error("patch lane busy at last row");

  // a finished patch must never overwrite a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    patch_stat.done |-> !merge_busy)
    else $error("patch result overwritten");

  // the row counter moves only on a taken request
  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(row_index))
    else $error("row counter moved without request");

endmodule
